>>> hdl/cek7_pkg.sv
package cek7_pkg;

    localparam int BYTE_W = 8;
    localparam int HIST_W = 7;
    localparam int WORD_W = 64;
    localparam int FMT_W  = 2;
    localparam int PAIR_W = 2 * BYTE_W;

    localparam logic [HIST_W-1:0] TAPS_A      = 7'h4F;
    localparam logic [HIST_W-1:0] TAPS_B      = 7'h6D;
    localparam logic [3:0]        SPREAD_ONE  = 4'hC;
    localparam logic [3:0]        SPREAD_ZERO = 4'h3;

    localparam logic [FMT_W-1:0] FMT_PAIRS  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_NIBBLE = 2'd1;
    localparam logic [FMT_W-1:0] FMT_SPREAD = 2'd2;
    localparam logic [FMT_W-1:0] FMT_RESET  = FMT_NIBBLE;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [HIST_W-1:0] hist;
    } item_t;

endpackage

>>> hdl/cek7_history.sv
module cek7_history (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cek7_pkg::BYTE_W-1:0]   in_byte,
    input  logic                          in_clear,
    input  logic                          advance,
    output logic                          item_valid,
    output cek7_pkg::item_t               item
);

    logic                        valid_reg;
    logic                        valid_next;
    cek7_pkg::item_t             item_reg;
    logic [cek7_pkg::HIST_W-1:0] hist_reg;
    logic [cek7_pkg::HIST_W-1:0] hist_next;
    logic                        accept;

    assign in_ready   = !valid_reg || advance;
    assign accept     = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // after eight shifts the register holds the low seven bits reversed
    always_comb
    begin
        hist_next = hist_reg;
        if (accept)
        begin
            for (int j = 0; j < cek7_pkg::HIST_W; j++)
            begin
                hist_next[j] = in_clear ? 1'b0 : in_byte[cek7_pkg::HIST_W-1-j];
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hist_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            hist_reg  <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data_byte <= in_byte;
            item_reg.hist      <= hist_reg;
        end
    end

endmodule

>>> hdl/cek7_encode.sv
module cek7_encode (
    input  cek7_pkg::item_t               item,
    input  logic [cek7_pkg::FMT_W-1:0]    output_format,
    output logic [cek7_pkg::WORD_W-1:0]   code_word
);

    logic [cek7_pkg::PAIR_W-1:0] pairs;
    logic [31:0]                 nibbles;
    logic [cek7_pkg::WORD_W-1:0] spread;

    always_comb
    begin
        logic [cek7_pkg::HIST_W-1:0] h_pre;
        logic [cek7_pkg::HIST_W-1:0] h_post;
        logic                        a_pre;
        logic                        b_pre;
        logic                        a_post;
        logic                        b_post;
        pairs   = '0;
        nibbles = '0;
        h_pre   = item.hist;
        for (int k = 0; k < cek7_pkg::BYTE_W; k++)
        begin
            h_post = {item.data_byte[cek7_pkg::BYTE_W-1-k], h_pre[cek7_pkg::HIST_W-1:1]};
            a_pre  = ^(h_pre & cek7_pkg::TAPS_A);
            b_pre  = ^(h_pre & cek7_pkg::TAPS_B);
            a_post = ^(h_post & cek7_pkg::TAPS_A);
            b_post = ^(h_post & cek7_pkg::TAPS_B);
            pairs[cek7_pkg::PAIR_W-1-2*k -: 2] = {a_pre, b_pre};
            nibbles[31-4*k -: 4]               = {a_post, a_post, b_post, b_post};
            h_pre = h_post;
        end
    end

    always_comb
    begin
        for (int i = 0; i < cek7_pkg::PAIR_W; i++)
        begin
            spread[4*i+3 -: 4] = pairs[i] ? cek7_pkg::SPREAD_ONE : cek7_pkg::SPREAD_ZERO;
        end
    end

    always_comb
    begin
        unique case (output_format)
            cek7_pkg::FMT_PAIRS:  code_word = {{(cek7_pkg::WORD_W-cek7_pkg::PAIR_W){1'b0}}, pairs};
            cek7_pkg::FMT_NIBBLE: code_word = {32'd0, nibbles};
            cek7_pkg::FMT_SPREAD: code_word = spread;
            default:              code_word = '0;
        endcase
    end

endmodule

>>> hdl/conv_encoder_k7_with_spreading_unit.sv
// Rate 1/2, K=7 convolutional encoder (taps A = bits 0,1,2,3,6, B = bits 0,2,3,5,6,
// bit 6 newest) taking one byte per word, MSB first, and giving one 64-bit code
// word per input word, right aligned, first code bit most significant. cfg_data
// selects the form (reset 1): 0 = 16-bit delayed A/B pairs, 1 = 32-bit nibbles
// AABB after each shift, 2 = format 0 with each bit spread to 1100 or 0011,
// 3 = all zeros. tlast on the input clears the history after that byte. One word
// per cycle sustained while m_axis_tready is high; a word passes the input and the
// output register around the unrolled eight-bit XOR network. Write cfg only idle.
module conv_encoder_k7_with_spreading_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cek7_pkg::FMT_W-1:0]    cfg_data,       // output_format
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cek7_pkg::BYTE_W-1:0]   s_axis_tdata,   // data_byte
    input  logic                          s_axis_tlast,   // clear_after
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [cek7_pkg::WORD_W-1:0]   m_axis_tdata    // code_word
);

    logic [cek7_pkg::FMT_W-1:0]  format_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [cek7_pkg::WORD_W-1:0] out_data_reg;
    logic                        load;
    logic                        item_valid;
    cek7_pkg::item_t             item;
    logic [cek7_pkg::WORD_W-1:0] code_word;

    assign cfg_ready     = 1'b1;
    assign load          = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    cek7_history u_history (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_clear   (s_axis_tlast),
        .advance    (load),
        .item_valid (item_valid),
        .item       (item)
    );

    cek7_encode u_encode (
        .item          (item),
        .output_format (format_reg),
        .code_word     (code_word)
    );

    assign out_valid_next = load ? item_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg    <= cek7_pkg::FMT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                format_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && item_valid)
        begin
            out_data_reg <= code_word;
        end
    end

endmodule
